/* hdl/newmark_sliding_block_integrator_macros.svh */
// Assertion macros shared by the sliding block integrator RTL.
`ifndef NEWMARK_SLIDING_BLOCK_INTEGRATOR_MACROS_SVH
`define NEWMARK_SLIDING_BLOCK_INTEGRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define NSBI_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define NSBI_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define NSBI_ASSERT_IMP(name, clk, rst, ante, cons)
`define NSBI_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

/* hdl/nsbi_pkg.sv */
// Types and constants of the sliding block integrator.
package nsbi_pkg;

   typedef logic signed [32:0] accel_type;   // Q16.16 relative acceleration
   typedef logic signed [63:0] prod_type;    // exact accel * time term product
   typedef logic signed [47:0] dist_type;    // Q23.24 velocity / displacement
   typedef logic        [46:0] vmag_type;    // velocity magnitude (always >= 0)
   typedef logic        [30:0] tstep_type;   // Q1.30 time terms
   typedef logic        [47:0] t1_type;      // v_prev * dt term
   typedef logic signed [43:0] t2_type;      // acceleration term
   typedef logic        [1:0]  csr_idx_type;

   typedef struct packed {
      logic first;
      logic fin;
   } flg_type;

   localparam csr_idx_type CSR_YIELD = 2'd0;
   localparam csr_idx_type CSR_DT    = 2'd1;
   localparam csr_idx_type CSR_DT6   = 2'd2;

   localparam logic signed [31:0] YIELD_RST = 32'sd0;
   localparam tstep_type DT_RST  = 31'd10737418;
   localparam tstep_type DT6_RST = 31'd17896;

   localparam dist_type S48_MAX     = 48'sh7FFF_FFFF_FFFF;
   localparam dist_type S48_MIN     = 48'sh8000_0000_0000;
   localparam dist_type FAILED_DISP = 48'sd167772160;   // 10.0 in Q23.24

endpackage

/* hdl/nsbi_if.sv */
// Handshake channel interfaces: sample input, result output, register write.
interface nsbi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_sample;
   logic               first_sample;
   logic               record_end;

   modport source (output valid, accel_sample, first_sample, record_end, input ready);
   modport sink   (input valid, accel_sample, first_sample, record_end, output ready);
endinterface

interface nsbi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] displacement;
   logic               is_final;
   logic               saturated;

   modport source (output valid, displacement, is_final, saturated, input ready);
   modport sink   (input valid, displacement, is_final, saturated, output ready);
endinterface

interface nsbi_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/nsbi_prod.sv */
// Product stage: relative acceleration times dt and times dt^2/6.
module nsbi_prod
   import nsbi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      valid_in,
   input  accel_type a_in,
   input  flg_type   flg_in,
   input  logic      use_prev,
   input  accel_type a_prev,
   input  tstep_type dt,
   input  tstep_type dt6,
   output logic      valid_out,
   output accel_type a_out,
   output prod_type  pa_out,
   output prod_type  pb_out,
   output flg_type   flg_out
);

   accel_type op;
   prod_type  pa_in;
   prod_type  pb_in;
   logic      valid_ff;
   accel_type a_ff;
   prod_type  pa_ff;
   prod_type  pb_ff;
   flg_type   flg_ff;

   // on a refresh the stored previous acceleration is re-multiplied
   assign op    = use_prev ? a_prev : a_in;
   assign pa_in = 64'(op) * 64'($signed({1'b0, dt}));
   assign pb_in = 64'(op) * 64'($signed({1'b0, dt6}));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         flg_ff <= flg_in;
      end
   end

   assign valid_out = valid_ff;
   assign a_out     = a_ff;
   assign pa_out    = pa_ff;
   assign pb_out    = pb_ff;
   assign flg_out   = flg_ff;

endmodule

/* hdl/nsbi_vel.sv */
// Velocity recurrence stage: trapezoid update, clamp at zero, saturation.
`include "newmark_sliding_block_integrator_macros.svh"
module nsbi_vel
   import nsbi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      valid_in,
   input  accel_type a_in,
   input  prod_type  pa_in,
   input  prod_type  pb_in,
   input  flg_type   flg_in,
   input  logic      fail,
   input  logic      refresh_ld,
   output accel_type a_prev,
   output logic      valid_out,
   output vmag_type  vprev_out,
   output prod_type  pbp_out,
   output prod_type  pbe_out,
   output logic      clipv_out,
   output flg_type   flg_out
);

   dist_type  vel_ff;
   accel_type aprev_ff;
   prod_type  pa_prev_ff;
   prod_type  pb_prev_ff;
   logic      valid_ff;
   vmag_type  vprev_ff;
   prod_type  pbp_ff;
   prod_type  pbe_ff;
   logic      clipv_ff;
   flg_type   flg_ff;

   logic signed [64:0] acc_sum;
   logic signed [41:0] vinc;
   logic        [48:0] vsum;
   logic               vneg;
   logic               vover;
   dist_type           vnew;
   logic               step;

   // (a_prev + a) * dt is the sum of two exact products; floor of /2^23
   assign acc_sum = 65'(pa_prev_ff) + 65'(pa_in);
   assign vinc    = acc_sum[64:23];
   assign vsum    = {1'b0, vel_ff} + 49'(vinc);
   assign vneg    = vsum[48];
   assign vover   = vsum[47] & ~vsum[48];
   assign vnew    = vneg ? '0 : (vover ? S48_MAX : dist_type'(vsum[47:0]));
   assign step    = en & valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         vel_ff     <= '0;
         aprev_ff   <= '0;
         pa_prev_ff <= '0;
         pb_prev_ff <= '0;
      end else begin
         if (en) begin
            valid_ff <= valid_in;
         end
         if (refresh_ld) begin
            // time terms changed: reload products of the held acceleration
            pa_prev_ff <= pa_in;
            pb_prev_ff <= pb_in;
         end else if (step) begin
            if (flg_in.first) begin
               vel_ff     <= '0;
               aprev_ff   <= '0;
               pa_prev_ff <= '0;
               pb_prev_ff <= '0;
            end else if (!fail) begin
               vel_ff     <= vnew;
               aprev_ff   <= vneg ? '0 : a_in;
               pa_prev_ff <= vneg ? '0 : pa_in;
               pb_prev_ff <= vneg ? '0 : pb_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vprev_ff <= vel_ff[46:0];
         pbp_ff   <= pb_prev_ff;
         pbe_ff   <= vneg ? '0 : pb_in;
         clipv_ff <= vover;
         flg_ff   <= flg_in;
      end
   end

   assign a_prev    = aprev_ff;
   assign valid_out = valid_ff;
   assign vprev_out = vprev_ff;
   assign pbp_out   = pbp_ff;
   assign pbe_out   = pbe_ff;
   assign clipv_out = clipv_ff;
   assign flg_out   = flg_ff;

   `NSBI_ASSERT_IMP(a_vel_nonneg, clock, reset, 1'b1, !vel_ff[47])
   `NSBI_ASSERT_NXT(a_clamp_clears, clock, reset,
      step && !refresh_ld && !flg_in.first && !fail && vneg,
      vel_ff == '0 && aprev_ff == '0 && pa_prev_ff == '0 && pb_prev_ff == '0)

endmodule

/* hdl/nsbi_tterm.sv */
// Displacement term stages: split v_prev*dt product and the dt^2/6 term.
module nsbi_tterm
   import nsbi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en4,
   input  logic      en5,
   input  logic      valid_in,
   input  vmag_type  vprev,
   input  prod_type  pbp,
   input  prod_type  pbe,
   input  logic      clipv_in,
   input  flg_type   flg_in,
   input  tstep_type dt,
   output logic      valid4_out,
   output logic      valid_out,
   output t1_type    t1_out,
   output t2_type    t2_out,
   output logic      clipv_out,
   output flg_type   flg_out
);

   logic [61:0]        ph_in;
   logic [62:0]        pl_in;
   logic signed [65:0] t2_sum;
   logic [77:0]        t1_full;

   logic        valid4_ff;
   logic [61:0] ph_ff;
   logic [62:0] pl_ff;
   t2_type      t2a_ff;
   logic        clipv4_ff;
   flg_type     flg4_ff;

   logic        valid5_ff;
   t1_type      t1_ff;
   t2_type      t2b_ff;
   logic        clipv5_ff;
   flg_type     flg5_ff;

   // v_prev * dt as high and low halves of dt
   assign ph_in   = 62'(vprev) * 62'(dt[30:16]);
   assign pl_in   = 63'(vprev) * 63'(dt[15:0]);
   assign t2_sum  = (66'(pbp) <<< 1) + 66'(pbe);
   assign t1_full = {ph_ff, 16'b0} + 78'(pl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (en4) begin
            valid4_ff <= valid_in;
         end
         if (en5) begin
            valid5_ff <= valid4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         ph_ff     <= ph_in;
         pl_ff     <= pl_in;
         t2a_ff    <= t2_sum[65:22];
         clipv4_ff <= clipv_in;
         flg4_ff   <= flg_in;
      end
      if (en5) begin
         t1_ff     <= t1_full[77:30];
         t2b_ff    <= t2a_ff;
         clipv5_ff <= clipv4_ff;
         flg5_ff   <= flg4_ff;
      end
   end

   assign valid4_out = valid4_ff;
   assign valid_out  = valid5_ff;
   assign t1_out     = t1_ff;
   assign t2_out     = t2b_ff;
   assign clipv_out  = clipv5_ff;
   assign flg_out    = flg5_ff;

endmodule

/* hdl/nsbi_disp.sv */
// Displacement accumulator with saturation, sticky clip flag and result register.
`include "newmark_sliding_block_integrator_macros.svh"
module nsbi_disp
   import nsbi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     valid_in,
   input  t1_type   t1,
   input  t2_type   t2,
   input  logic     clipv,
   input  flg_type  flg_in,
   input  logic     fail,
   output logic     valid_out,
   output dist_type disp_out,
   output logic     fin_out,
   output logic     sat_out
);

   dist_type           disp_ff;
   logic               sat_ff;
   logic               valid_ff;
   dist_type           odisp_ff;
   logic               ofin_ff;
   logic               osat_ff;

   logic signed [50:0] dsum;
   logic               clipd;
   dist_type           dnew;
   logic               sat_new;

   assign dsum    = 51'(disp_ff) + 51'({3'b0, t1}) + 51'(t2);
   assign clipd   = !(dsum[50:47] == 4'b0000 || dsum[50:47] == 4'b1111);
   assign dnew    = clipd ? (dsum[50] ? S48_MIN : S48_MAX) : dist_type'(dsum[47:0]);
   assign sat_new = sat_ff | clipv | clipd;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         disp_ff  <= '0;
         sat_ff   <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
         if (valid_in) begin
            if (flg_in.first) begin
               disp_ff <= '0;
               sat_ff  <= 1'b0;
            end else if (!fail) begin
               disp_ff <= dnew;
               sat_ff  <= sat_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ofin_ff <= flg_in.fin;
         if (fail) begin
            odisp_ff <= FAILED_DISP;
            osat_ff  <= 1'b0;
         end else if (flg_in.first) begin
            odisp_ff <= '0;
            osat_ff  <= 1'b0;
         end else begin
            odisp_ff <= dnew;
            osat_ff  <= sat_new;
         end
      end
   end

   assign valid_out = valid_ff;
   assign disp_out  = odisp_ff;
   assign fin_out   = ofin_ff;
   assign sat_out   = osat_ff;

   `NSBI_ASSERT_IMP(a_sat_sticky, clock, reset, valid_ff && osat_ff, sat_ff)

endmodule

/* hdl/newmark_sliding_block_integrator.sv */
// Top level of the rigid sliding block (Newmark) displacement integrator.
//
//  channel  dir  handshake      payload
//  req_bus  in   valid/ready    accel_sample (Q15.16), first_sample, record_end
//  rsp_bus  out  valid/ready    displacement (Q23.24), is_final, saturated
//  csr_bus  in   valid/ready    index (0 yield, 1 dt, 2 dt^2/6), data
//
// One word in and one word out per cycle while rsp_bus is ready and no refresh
// runs. A word passes the input, product, velocity, term and result registers.
// The rate is set by the velocity stage, whose state feeds back, and by the
// displacement accumulator, which closes its own loop. Each stage holds only
// when the stage after it is full and held, so bubbles close up and new words
// are taken while a result waits on rsp_bus. Any register write blocks req_bus
// in the refresh states while the stored products of the previous acceleration
// are rebuilt with the new time terms. Reset is synchronous and active high;
// it restores register defaults and clears all integrator state.
`include "newmark_sliding_block_integrator_macros.svh"
module newmark_sliding_block_integrator
   import nsbi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   nsbi_req_if.sink   req_bus,
   nsbi_rsp_if.source rsp_bus,
   nsbi_csr_if.sink   csr_bus
);

   // refresh sequence after a register write
   localparam logic [1:0] RFS_IDLE = 2'd0;
   localparam logic [1:0] RFS_LOAD = 2'd1;   // load stored products
   localparam logic [1:0] RFS_MUL  = 2'd2;   // multiply held acceleration

   logic signed [31:0] yield_ff;
   tstep_type          dt_ff;
   tstep_type          dt6_ff;
   logic [1:0]         rfs_cnt_ff;

   logic      csr_acc;
   logic      req_acc;
   logic      fail;

   // pipeline enables, output side first
   logic en_o, en5, en4, en3, en2, en1;

   // stage 1: input register
   logic      valid1_ff;
   accel_type a1_ff;
   flg_type   flg1_ff;
   accel_type a1_in;

   // stage 2
   logic      valid2;
   accel_type a2;
   prod_type  pa2;
   prod_type  pb2;
   flg_type   flg2;

   // stage 3
   accel_type a_prev;
   logic      valid3;
   vmag_type  vprev3;
   prod_type  pbp3;
   prod_type  pbe3;
   logic      clipv3;
   flg_type   flg3;

   // stages 4 and 5
   logic      valid4;
   logic      valid5;
   t1_type    t1_5;
   t2_type    t2_5;
   logic      clipv5;
   flg_type   flg5;

   logic      out_valid;
   dist_type  out_disp;
   logic      out_fin;
   logic      out_sat;

   assign fail    = yield_ff[31];   // failed slope: fixed result, state frozen
   assign csr_acc = csr_bus.valid & csr_bus.ready;
   assign req_acc = req_bus.valid & req_bus.ready;

   assign en_o = !out_valid || rsp_bus.ready;
   assign en5  = !valid5    || en_o;
   assign en4  = !valid4    || en5;
   assign en3  = !valid3    || en4;
   assign en2  = !valid2    || en3;
   assign en1  = !valid1_ff || en2;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = en1 && (rfs_cnt_ff == RFS_IDLE);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         yield_ff <= YIELD_RST;
         dt_ff    <= DT_RST;
         dt6_ff   <= DT6_RST;
      end else if (csr_acc) begin
         unique case (csr_bus.index)
            CSR_YIELD: yield_ff <= csr_bus.data;
            CSR_DT:    dt_ff    <= csr_bus.data[30:0];
            CSR_DT6:   dt6_ff   <= csr_bus.data[30:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rfs_cnt_ff <= RFS_IDLE;
      end else if (csr_acc) begin
         rfs_cnt_ff <= RFS_MUL;
      end else if (rfs_cnt_ff != RFS_IDLE) begin
         rfs_cnt_ff <= rfs_cnt_ff - 2'd1;
      end
   end

   // stage 1: relative acceleration, exact in 33 bits
   assign a1_in = 33'(req_bus.accel_sample) - 33'(yield_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en1) begin
         valid1_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a1_ff       <= a1_in;
         flg1_ff.first <= req_bus.first_sample;
         flg1_ff.fin   <= req_bus.record_end;
      end
   end

   nsbi_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .en        (en2),
      .valid_in  (valid1_ff),
      .a_in      (a1_ff),
      .flg_in    (flg1_ff),
      .use_prev  (rfs_cnt_ff == RFS_MUL),
      .a_prev    (a_prev),
      .dt        (dt_ff),
      .dt6       (dt6_ff),
      .valid_out (valid2),
      .a_out     (a2),
      .pa_out    (pa2),
      .pb_out    (pb2),
      .flg_out   (flg2)
   );

   nsbi_vel u_vel (
      .clock      (clock),
      .reset      (reset),
      .en         (en3),
      .valid_in   (valid2),
      .a_in       (a2),
      .pa_in      (pa2),
      .pb_in      (pb2),
      .flg_in     (flg2),
      .fail       (fail),
      .refresh_ld (rfs_cnt_ff == RFS_LOAD),
      .a_prev     (a_prev),
      .valid_out  (valid3),
      .vprev_out  (vprev3),
      .pbp_out    (pbp3),
      .pbe_out    (pbe3),
      .clipv_out  (clipv3),
      .flg_out    (flg3)
   );

   nsbi_tterm u_tterm (
      .clock      (clock),
      .reset      (reset),
      .en4        (en4),
      .en5        (en5),
      .valid_in   (valid3),
      .vprev      (vprev3),
      .pbp        (pbp3),
      .pbe        (pbe3),
      .clipv_in   (clipv3),
      .flg_in     (flg3),
      .dt         (dt_ff),
      .valid4_out (valid4),
      .valid_out  (valid5),
      .t1_out     (t1_5),
      .t2_out     (t2_5),
      .clipv_out  (clipv5),
      .flg_out    (flg5)
   );

   nsbi_disp u_disp (
      .clock     (clock),
      .reset     (reset),
      .en        (en_o),
      .valid_in  (valid5),
      .t1        (t1_5),
      .t2        (t2_5),
      .clipv     (clipv5),
      .flg_in    (flg5),
      .fail      (fail),
      .valid_out (out_valid),
      .disp_out  (out_disp),
      .fin_out   (out_fin),
      .sat_out   (out_sat)
   );

   assign rsp_bus.valid        = out_valid;
   assign rsp_bus.displacement = out_disp;
   assign rsp_bus.is_final     = out_fin;
   assign rsp_bus.saturated    = out_sat;

   // a register write must hold off new words while products are rebuilt
   `NSBI_ASSERT_NXT(a_csr_blocks_req, clock, reset, csr_acc, !req_bus.ready)
   // a failed slope always reports the fixed displacement, never a clip
   `NSBI_ASSERT_IMP(a_fail_result, clock, reset, out_valid && fail,
      out_disp == FAILED_DISP && !out_sat)

endmodule
